// ===== design/mchl_pkg.sv =====
// Package for the multiclass hinge loss block: field widths, register
// indexes, controller states and the command/status structs.
// No dependencies; compile first.
package mchl_pkg;

  localparam int SCORE_W    = 16;
  localparam int LABEL_W    = 8;
  localparam int HINGE_W    = 16;
  localparam int GRAD_W     = 24;
  localparam int LOSS_W     = 47;
  localparam int ACC_W      = 48;
  localparam int CNT_CFG_W  = 9;
  localparam int SCALE_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int MUL_W      = 17;  // operand width of the shared multiplier
  localparam int PROD_W     = 2 * MUL_W;
  localparam int TERM_W     = 32;  // squared hinge fits in 31 bits

  localparam int DEF_MAX_SAMPLES = 256;
  localparam int DEF_MAX_CLASSES = 256;

  localparam logic [HINGE_W-1:0] HINGE_ONE = HINGE_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORM_MODE      = 2'd0,
    REG_NUM_SAMPLES    = 2'd1,
    REG_NUM_CLASSES    = 2'd2,
    REG_GRADIENT_SCALE = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    NORM_L1 = 1'b0,
    NORM_L2 = 1'b1
  } norm_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_G,
    ST_MUL_T,
    ST_FIN,
    ST_DIV,
    ST_PUSH
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;    // capture the hinge of the accepted score
    logic mul_sq;     // multiplier computes hinge * hinge
    logic cap_grad;   // capture hinge * scale
    logic cap_term;   // capture hinge * hinge
    logic finish;     // gradient, accumulate, advance counters
    logic div_start;  // start the loss division
    logic load_out;   // load the output register
  } mchl_cmd_t;

  typedef struct packed {
    logic last;       // current element closes the batch
    logic div_done;   // divider finishes at this edge
  } mchl_sts_t;

endpackage

// ===== design/mchl_in_if.sv =====
// Input channel of the hinge loss block: valid/ready plus score and label.
// Depends on mchl_pkg.
interface mchl_in_if;
  import mchl_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic        [LABEL_W-1:0] label;

  modport source (output valid, output score, output label, input ready);
  modport sink   (input valid, input score, input label, output ready);
endinterface

// ===== design/mchl_out_if.sv =====
// Result channel of the hinge loss block: valid/ready plus hinge, gradient,
// loss and last. Depends on mchl_pkg.
interface mchl_out_if;
  import mchl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic       [HINGE_W-1:0] hinge;
  logic signed [GRAD_W-1:0] gradient;
  logic        [LOSS_W-1:0] loss;
  logic                     last;

  modport source (output valid, output hinge, output gradient, output loss, output last,
                  input ready);
  modport sink   (input valid, input hinge, input gradient, input loss, input last,
                  output ready);
endinterface

// ===== design/multiclass_hinge_loss.sv =====
// Top level of the multiclass hinge loss block: controller plus datapath.
// Depends on mchl_pkg, mchl_in_if, mchl_out_if, mchl_ctrl, mchl_dp.
//
// Scores stream in sample-major, class-minor, each with its sample's label;
// every transfer in yields one transfer out carrying the hinge max(0, 1 + s)
// (s negated at the label class), the saturated gradient (L1: sign times
// gradient_scale, L2: 2 * hinge * gradient_scale floored to Q8.8, negated at
// the label), and on the batch's final element the loss, i.e. the sum of
// hinges (L1, Q8.8) or squared hinges (L2, Q16.16) divided by num_samples.
// An item passes from transfer in to the output register in steps: form
// the hinge, the single shared 17x17 multiplier for hinge * scale, then
// for hinge * hinge, finish the gradient and accumulate, load the output
// register once it is free. The last element of a batch also passes through
// the bit-serial restoring divider before that load. A new item is taken
// while an earlier result still waits in the output register. Write the
// configuration registers only while no item is in flight; the class and
// sample counters and the accumulator return to zero after each batch.

module multiclass_hinge_loss #(
  parameter int MAX_SAMPLES = mchl_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_CLASSES = mchl_pkg::DEF_MAX_CLASSES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mchl_in_if.sink                         in_ch,
  mchl_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  mchl_pkg::cfg_idx_t              cfg_index,
  input  logic [mchl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mchl_pkg::*;

  mchl_cmd_t cmd;
  mchl_sts_t sts;

  // Handshake sequencing
  mchl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic, counters, configuration and output register
  mchl_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_score     (in_ch.score),
    .in_label     (in_ch.label),
    .cmd          (cmd),
    .sts          (sts),
    .out_hinge    (out_ch.hinge),
    .out_gradient (out_ch.gradient),
    .out_loss     (out_ch.loss),
    .out_last     (out_ch.last)
  );

endmodule

// ===== design/mchl_div.sv =====
// Restoring divider for the batch loss: one quotient bit per cycle.
// Depends on mchl_pkg.
module mchl_div #(
  parameter int NSW = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mchl_pkg::ACC_W-1:0] dividend,
  input  logic [NSW-1:0]            divisor,
  output logic                      done,
  output logic [mchl_pkg::ACC_W-1:0] quotient
);
  import mchl_pkg::*;

  localparam int CW = $clog2(ACC_W);

  logic              busy_r, busy_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [NSW-1:0]    rem_r;
  logic [ACC_W-1:0]  quo_r;
  logic [NSW:0]      rem_sh;
  logic              ge;

  assign rem_sh   = {rem_r, quo_r[ACC_W-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign done     = busy_r && (cnt_r == CW'(ACC_W - 1));
  assign quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CW'(1);
      if (done) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? NSW'(rem_sh - {1'b0, divisor}) : rem_sh[NSW-1:0];
      quo_r <= {quo_r[ACC_W-2:0], ge};
    end
  end

endmodule

// ===== design/mchl_ctrl.sv =====
// Controller of the hinge loss block: sequences multiply, finish, divide
// and output transfer. Depends on mchl_pkg.
module mchl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mchl_pkg::mchl_sts_t sts,
  output mchl_pkg::mchl_cmd_t cmd
);
  import mchl_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MUL_G;
        end
      end
      ST_MUL_G: begin
        cmd.cap_grad = 1'b1;
        state_nxt    = ST_MUL_T;
      end
      ST_MUL_T: begin
        cmd.mul_sq   = 1'b1;
        cmd.cap_term = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        if (sts.last) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/mchl_dp.sv =====
// Datapath of the hinge loss block: configuration registers, counters,
// shared multiplier, accumulator, output register. Depends on mchl_pkg, mchl_div.
module mchl_dp #(
  parameter int MAX_SAMPLES = mchl_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_CLASSES = mchl_pkg::DEF_MAX_CLASSES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  mchl_pkg::cfg_idx_t                 cfg_index,
  input  logic [mchl_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [mchl_pkg::SCORE_W-1:0] in_score,
  input  logic [mchl_pkg::LABEL_W-1:0]       in_label,
  input  mchl_pkg::mchl_cmd_t                cmd,
  output mchl_pkg::mchl_sts_t                sts,
  output logic [mchl_pkg::HINGE_W-1:0]       out_hinge,
  output logic signed [mchl_pkg::GRAD_W-1:0] out_gradient,
  output logic [mchl_pkg::LOSS_W-1:0]        out_loss,
  output logic                               out_last
);
  import mchl_pkg::*;

  localparam int CW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int SW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int NCW = $clog2(MAX_CLASSES + 1);
  localparam int NSW = $clog2(MAX_SAMPLES + 1);
  localparam int LW  = (CW > LABEL_W) ? CW : LABEL_W;

  localparam logic signed [PROD_W-1:0] GMAX = PROD_W'((1 << (GRAD_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] GMIN = -PROD_W'(1 << (GRAD_W - 1));

  function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [PROD_W-1:0] v);
    if (v > GMAX) return GMAX[GRAD_W-1:0];
    if (v < GMIN) return GMIN[GRAD_W-1:0];
    return v[GRAD_W-1:0];
  endfunction

  // Configuration registers
  norm_mode_t                 norm_r;
  logic [CNT_CFG_W-1:0]       nsamp_r;
  logic [CNT_CFG_W-1:0]       nclass_r;
  logic signed [SCALE_W-1:0]  scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r   <= NORM_L1;
      nsamp_r  <= CNT_CFG_W'(1);
      nclass_r <= CNT_CFG_W'(2);
      scale_r  <= SCALE_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NORM_MODE:      norm_r   <= norm_mode_t'(cfg_data[0]);
        REG_NUM_SAMPLES:    nsamp_r  <= cfg_data[CNT_CFG_W-1:0];
        REG_NUM_CLASSES:    nclass_r <= cfg_data[CNT_CFG_W-1:0];
        REG_GRADIENT_SCALE: scale_r  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped counts
  logic [NCW-1:0] nc;
  logic [NSW-1:0] ns;

  always_comb begin
    if (nclass_r == '0)                           nc = NCW'(1);
    else if (32'(nclass_r) > 32'(MAX_CLASSES))    nc = NCW'(MAX_CLASSES);
    else                                          nc = NCW'(nclass_r);
    if (nsamp_r == '0)                            ns = NSW'(1);
    else if (32'(nsamp_r) > 32'(MAX_SAMPLES))     ns = NSW'(MAX_SAMPLES);
    else                                          ns = NSW'(nsamp_r);
  end

  // Counters
  logic [CW-1:0] cc_r;
  logic [SW-1:0] sc_r;
  logic          class_end;
  logic          last;

  assign class_end = (CW'(1) + {1'b0, cc_r}) >= (CW + 1)'(nc);
  assign last      = class_end && ((SW'(1) + {1'b0, sc_r}) >= (SW + 1)'(ns));

  // Hinge of the accepted score
  logic                      at_lbl;
  logic signed [SCORE_W:0]   v;
  logic signed [SCORE_W+1:0] hs;
  logic [HINGE_W-1:0]        h_in;
  logic [HINGE_W-1:0]        h_r;
  logic                      at_lbl_r;

  assign at_lbl = (LW'(cc_r) == LW'(in_label));
  assign v      = at_lbl ? -(SCORE_W + 1)'(in_score) : (SCORE_W + 1)'(in_score);
  assign hs     = (SCORE_W + 2)'(v) + (SCORE_W + 2)'($signed({1'b0, HINGE_ONE}));
  assign h_in   = hs[SCORE_W+1] ? '0 : hs[HINGE_W-1:0];

  // Shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_g_r;
  logic [TERM_W-1:0]        prod_t_r;

  assign mul_a = $signed({1'b0, h_r});
  assign mul_b = cmd.mul_sq ? $signed({1'b0, h_r}) : MUL_W'(scale_r);
  assign prod  = mul_a * mul_b;

  // Gradient, accumulation
  logic signed [GRAD_W-1:0] g_base;
  logic signed [GRAD_W-1:0] g_fin;
  logic [TERM_W-1:0]        term;
  logic [ACC_W:0]           acc_sum;
  logic [ACC_W-1:0]         acc_new;
  logic [ACC_W-1:0]         acc_r;

  always_comb begin
    if (norm_r == NORM_L2) begin
      g_base = sat_grad(prod_g_r >>> 7);  // 2*h*scale, floor to Q8.8
      term   = prod_t_r;
    end else begin
      g_base = (h_r != '0) ? GRAD_W'(scale_r) : '0;
      term   = TERM_W'(h_r);
    end
    g_fin   = at_lbl_r ? sat_grad(-PROD_W'(g_base)) : g_base;
    acc_sum = {1'b0, acc_r} + (ACC_W + 1)'(term);
    acc_new = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r  <= '0;
      sc_r  <= '0;
      acc_r <= '0;
    end else if (cmd.finish) begin
      if (last) begin
        cc_r  <= '0;
        sc_r  <= '0;
        acc_r <= '0;
      end else if (class_end) begin
        cc_r  <= '0;
        sc_r  <= sc_r + SW'(1);
        acc_r <= acc_new;
      end else begin
        cc_r  <= cc_r + CW'(1);
        acc_r <= acc_new;
      end
    end
  end

  // Payload registers
  logic [HINGE_W-1:0]       pend_hinge_r;
  logic signed [GRAD_W-1:0] pend_grad_r;
  logic                     pend_last_r;
  logic [ACC_W-1:0]         quo;
  logic                     div_done;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      h_r      <= h_in;
      at_lbl_r <= at_lbl;
    end
    if (cmd.cap_grad) prod_g_r <= prod;
    if (cmd.cap_term) prod_t_r <= prod[TERM_W-1:0];
    if (cmd.finish) begin
      pend_hinge_r <= h_r;
      pend_grad_r  <= g_fin;
      pend_last_r  <= last;
    end
    if (cmd.load_out) begin
      out_hinge    <= pend_hinge_r;
      out_gradient <= pend_grad_r;
      out_last     <= pend_last_r;
      if (!pend_last_r)        out_loss <= '0;
      else if (quo[ACC_W-1])   out_loss <= '1;
      else                     out_loss <= quo[LOSS_W-1:0];
    end
  end

  mchl_div #(.NSW(NSW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (acc_new),
    .divisor  (ns),
    .done     (div_done),
    .quotient (quo)
  );

  assign sts.last     = last;
  assign sts.div_done = div_done;

endmodule
